FILE: hdl/dedup_fifo_queue_assert.svh
// ----------------------------------------------------------------------------
// Dedup FIFO queue assertion macros
// Short forms for the concurrent checks used inside the queue RTL.
// ----------------------------------------------------------------------------
`ifndef DEDUP_FIFO_QUEUE_ASSERT_SVH
`define DEDUP_FIFO_QUEUE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define DFQ_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DFQ_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: hdl/dfq_pkg.sv
// ----------------------------------------------------------------------------
// Dedup FIFO queue package
// Operation and status codes, field widths and the beat types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfq_pkg;

	// Fixed field widths of the channel beats.
	localparam int OpW     = 3;
	localparam int RecW    = 16;
	localparam int StatusW = 3;
	localparam int WaitW   = 5;

	// Operation codes.
	localparam logic [OpW-1:0] OP_ENQUEUE = 3'd0;
	localparam logic [OpW-1:0] OP_DEQUEUE = 3'd1;
	localparam logic [OpW-1:0] OP_LIST    = 3'd2;
	localparam logic [OpW-1:0] OP_DRAIN   = 3'd3;
	localparam logic [OpW-1:0] OP_CLOSE   = 3'd4;

	// Status codes.
	localparam logic [StatusW-1:0] ST_QUEUED    = 3'd0;
	localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
	localparam logic [StatusW-1:0] ST_SERVED    = 3'd3;
	localparam logic [StatusW-1:0] ST_EMPTY     = 3'd4;
	localparam logic [StatusW-1:0] ST_LISTED    = 3'd5;
	localparam logic [StatusW-1:0] ST_DISCARDED = 3'd6;
	localparam logic [StatusW-1:0] ST_CLOSED    = 3'd7;

	// Request beat.
	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [RecW-1:0] record_number;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [RecW-1:0]    record_number_res;
		logic [StatusW-1:0] status;
		logic [WaitW-1:0]   waiting_count;
		logic               last;
	} rsp_t;

endpackage

FILE: hdl/dedup_fifo_queue.sv
// ----------------------------------------------------------------------------
// Dedup FIFO queue
// First-in first-out queue of record numbers that rejects duplicates.
// ----------------------------------------------------------------------------
// The queue holds its entries in one single-port-read entry memory with a
// registered read, and every operation that looks at stored entries walks
// them one memory read per cycle, but a walk that answers with entries holds
// its reads while the response register cannot take the beat. An enqueue
// walks every waiting entry and then finishes in its own state, a dequeue
// reads the head entry, and close or an operation on an empty queue gives a
// single response beat. The response register lets a new request beat be
// taken while the previous response beat still waits. Unknown operation
// codes are accepted and produce no response beat.
`timescale 1ns / 1ps

module dedup_fifo_queue #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int RECORD_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dfq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dfq_pkg::rsp_t rsp
);

	import dfq_pkg::*;

	localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int ExtW = RECORD_WIDTH + RecW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_ENQ_FIN,
		S_SINGLE
	} state_t;

	typedef enum logic [1:0] {
		K_SEARCH,
		K_DEQ,
		K_LIST,
		K_DRAIN
	} kind_t;

	state_t                  state_q;
	kind_t                   kind_q;
	logic [IdxW-1:0]         head_q;
	logic [IdxW-1:0]         tail_q;
	logic [IdxW-1:0]         ptr_q;
	logic [CntW-1:0]         count_q;
	logic [CntW-1:0]         len_q;
	logic [CntW-1:0]         issued_q;
	logic [CntW-1:0]         emit_q;
	logic [RECORD_WIDTH-1:0] rec_q;
	logic                    dup_q;
	logic [StatusW-1:0]      res_status_q;
	rsp_t                    out_q;
	logic                    out_valid_q;

	logic [RECORD_WIDTH-1:0] entry_mem [QUEUE_DEPTH];
	logic [RECORD_WIDTH-1:0] rd_data_s1;
	logic                    rd_valid_s1;

	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	logic                    acc_read;
	logic                    consume;
	logic                    issue;
	logic                    rd_en;
	logic [IdxW-1:0]         rd_addr;
	logic                    mem_we;
	logic                    full;
	logic                    last_beat;
	logic [ExtW-1:0]         req_rec_ext;
	logic [RECORD_WIDTH-1:0] req_rec;
	logic [ExtW-1:0]         rd_rec_ext;
	logic [RecW-1:0]         rd_rec;
	logic [CntW-1:0]         walk_wait;

	// Advance a slot index with wrap at the queue depth.
	function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
		logic [IdxW-1:0] r;
		if (p == IdxW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + IdxW'(1);
		end
		return r;
	endfunction

	// Record number width conversions between the ports and the memory.
	assign req_rec_ext = ExtW'(req.record_number);
	assign req_rec     = req_rec_ext[RECORD_WIDTH-1:0];
	assign rd_rec_ext  = ExtW'(rd_data_s1);
	assign rd_rec      = rd_rec_ext[RecW-1:0];

	// Handshakes and queue status.
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// The first read of a walk is issued in the cycle the request is taken.
	assign acc_read = accept && (count_q != '0) &&
		((req.op == OP_ENQUEUE) || (req.op == OP_DEQUEUE) ||
		 (req.op == OP_LIST) || (req.op == OP_DRAIN));

	// A read result is used at once by the search, or when the response
	// register is free for listed and served entries.
	assign consume = (state_q == S_WALK) && rd_valid_s1 &&
		((kind_q == K_SEARCH) || out_free);
	assign issue   = (state_q == S_WALK) && (issued_q != len_q) &&
		(!rd_valid_s1 || consume);
	assign rd_en   = acc_read || issue;
	assign rd_addr = (state_q == S_IDLE) ? head_q : ptr_q;

	assign last_beat = (emit_q == len_q - CntW'(1));
	assign mem_we    = (state_q == S_ENQ_FIN) && out_free && !dup_q && !full;

	// The response register takes a new beat in these cycles.
	assign out_load = (consume && (kind_q != K_SEARCH)) ||
		(((state_q == S_ENQ_FIN) || (state_q == S_SINGLE)) && out_free);

	// Waiting count reported with a walked entry.
	always_comb begin
		unique case (kind_q)
			K_LIST:  walk_wait = len_q;
			K_DRAIN: walk_wait = len_q - CntW'(1) - emit_q;
			K_DEQ:   walk_wait = count_q - CntW'(1);
			K_SEARCH: walk_wait = count_q;
		endcase
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[tail_q] <= rec_q;
		end
		if (rd_en) begin
			rd_data_s1 <= entry_mem[rd_addr];
		end
	end

	// Sequencer, queue pointers and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_SEARCH;
			head_q       <= '0;
			tail_q       <= '0;
			ptr_q        <= '0;
			count_q      <= '0;
			len_q        <= '0;
			issued_q     <= '0;
			emit_q       <= '0;
			rec_q        <= '0;
			dup_q        <= 1'b0;
			res_status_q <= ST_EMPTY;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end

			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (consume) begin
				rd_valid_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rec_q    <= req_rec;
						dup_q    <= 1'b0;
						emit_q   <= '0;
						ptr_q    <= wrap_inc(head_q);
						issued_q <= CntW'(1);
						unique case (req.op)
							OP_ENQUEUE: begin
								kind_q  <= K_SEARCH;
								len_q   <= count_q;
								state_q <= (count_q == '0) ? S_ENQ_FIN : S_WALK;
							end
							OP_DEQUEUE: begin
								kind_q       <= K_DEQ;
								len_q        <= CntW'(1);
								res_status_q <= ST_EMPTY;
								state_q      <= (count_q == '0) ? S_SINGLE : S_WALK;
							end
							OP_LIST: begin
								kind_q       <= K_LIST;
								len_q        <= count_q;
								res_status_q <= ST_EMPTY;
								state_q      <= (count_q == '0) ? S_SINGLE : S_WALK;
							end
							OP_DRAIN: begin
								kind_q       <= K_DRAIN;
								len_q        <= count_q;
								res_status_q <= ST_EMPTY;
								state_q      <= (count_q == '0) ? S_SINGLE : S_WALK;
							end
							OP_CLOSE: begin
								res_status_q <= (count_q != '0) ? ST_DISCARDED : ST_CLOSED;
								head_q       <= '0;
								tail_q       <= '0;
								count_q      <= '0;
								state_q      <= S_SINGLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_WALK: begin
					if (issue) begin
						ptr_q    <= wrap_inc(ptr_q);
						issued_q <= issued_q + CntW'(1);
					end
					if (consume) begin
						emit_q <= emit_q + CntW'(1);
						if (kind_q == K_SEARCH) begin
							if (rd_data_s1 == rec_q) begin
								dup_q <= 1'b1;
							end
						end else begin
							out_q.record_number_res <= rd_rec;
							out_q.status            <= (kind_q == K_LIST) ? ST_LISTED : ST_SERVED;
							out_q.waiting_count     <= WaitW'(walk_wait);
							out_q.last              <= last_beat;
						end
						if (last_beat) begin
							unique case (kind_q)
								K_SEARCH: begin
									state_q <= S_ENQ_FIN;
								end
								K_LIST: begin
									state_q <= S_IDLE;
								end
								K_DRAIN: begin
									head_q  <= '0;
									tail_q  <= '0;
									count_q <= '0;
									state_q <= S_IDLE;
								end
								K_DEQ: begin
									head_q  <= wrap_inc(head_q);
									count_q <= count_q - CntW'(1);
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end

				S_ENQ_FIN: begin
					if (out_free) begin
						out_q.record_number_res <= '0;
						out_q.last              <= 1'b1;
						priority if (dup_q) begin
							out_q.status        <= ST_DUPLICATE;
							out_q.waiting_count <= WaitW'(count_q);
						end else if (full) begin
							out_q.status        <= ST_FULL;
							out_q.waiting_count <= WaitW'(count_q);
						end else begin
							tail_q              <= wrap_inc(tail_q);
							count_q             <= count_q + CntW'(1);
							out_q.status        <= ST_QUEUED;
							out_q.waiting_count <= WaitW'(count_q + CntW'(1));
						end
						state_q <= S_IDLE;
					end
				end

				S_SINGLE: begin
					if (out_free) begin
						out_q.record_number_res <= '0;
						out_q.status            <= res_status_q;
						out_q.waiting_count     <= '0;
						out_q.last              <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Checks on the sequencer and queue bookkeeping.
	`include "dedup_fifo_queue_assert.svh"

	`DFQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(QUEUE_DEPTH), "entry count above depth")
	`DFQ_ASSERT_SAME(a_ptr_match, (count_q == '0) || full, head_q == tail_q, "head and tail disagree")
	`DFQ_ASSERT_SAME(a_no_write_full, mem_we, !full && !dup_q, "enqueue write while full")
	`DFQ_ASSERT_SAME(a_rd_in_walk, rd_valid_s1, state_q == S_WALK, "read data outside a walk")
	`DFQ_ASSERT_NEXT(a_walk_len, state_q == S_WALK, issued_q <= len_q, "walk read past its length")

endmodule

FILE: tb/tb_dedup_fifo_queue.sv
// ----------------------------------------------------------------------------
// Dedup FIFO queue testbench
// Drives request beats and checks each response beat against a behavioral
// model of the queue. The model covers duplicate rejection, the full status,
// serve, list, drain and close. A short directed sequence runs first. It is
// followed by random enqueue bursts and mixed operations, with random idle
// cycles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dedup_fifo_queue;
	import dfq_pkg::*;

	localparam int Depth        = 16;
	localparam int ItemTarget   = 420;
	localparam int StallLimit   = 2000;
	localparam int SettleCycles = 40;
	localparam int SteadyFrom   = 1500;
	localparam int SteadyTo     = 2500;
	localparam int PoolSize     = 24;

	// Operation codes the block accepts and ignores.
	localparam logic [OpW-1:0] OP_RESERVED_LO = 3'd5;
	localparam logic [OpW-1:0] OP_RESERVED_HI = 3'd7;

	typedef struct {
		req_t beat;
		bit   settle_first;
	} pending_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	pending_t        pending_q[$];
	rsp_t            expected_rsp_q[$];
	logic [RecW-1:0] waiting_q[$];
	int unsigned     predicted_count = 0;
	int unsigned     received_count  = 0;
	int unsigned     cycle_count     = 0;
	int unsigned     quiet_cycles    = 0;
	int unsigned     error_count     = 0;
	int unsigned     real_items      = 0;

	dedup_fifo_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Free-running clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rsp_t make_rsp(logic [RecW-1:0] rec, logic [StatusW-1:0] st,
			int unsigned cnt, bit fin);
		rsp_t r;
		r.record_number_res = rec;
		r.status            = st;
		r.waiting_count     = WaitW'(cnt);
		r.last              = fin;
		return r;
	endfunction

	// Apply one request to the queue model and queue up the response beats it
	// should cause. Returns the number of beats.
	function automatic int unsigned predict_results(req_t beat);
		int unsigned n;
		bit found;
		n = waiting_q.size();
		found = 1'b0;
		case (beat.op)
		OP_ENQUEUE: begin
			foreach (waiting_q[i])
				if (waiting_q[i] == beat.record_number)
					found = 1'b1;
			// The duplicate check wins over the full check.
			if (found) begin
				expected_rsp_q.push_back(make_rsp('0, ST_DUPLICATE, n, 1'b1));
			end else if (n >= Depth) begin
				expected_rsp_q.push_back(make_rsp('0, ST_FULL, n, 1'b1));
			end else begin
				waiting_q.push_back(beat.record_number);
				expected_rsp_q.push_back(make_rsp('0, ST_QUEUED, n + 1, 1'b1));
			end
			return 1;
		end
		OP_DEQUEUE: begin
			if (n == 0) begin
				expected_rsp_q.push_back(make_rsp('0, ST_EMPTY, 0, 1'b1));
			end else begin
				expected_rsp_q.push_back(make_rsp(waiting_q.pop_front(), ST_SERVED,
					n - 1, 1'b1));
			end
			return 1;
		end
		OP_LIST, OP_DRAIN: begin
			if (n == 0) begin
				expected_rsp_q.push_back(make_rsp('0, ST_EMPTY, 0, 1'b1));
				return 1;
			end
			// Listing keeps the entries; draining counts down and empties.
			for (int i = 0; i < n; i++) begin
				if (beat.op == OP_LIST)
					expected_rsp_q.push_back(make_rsp(waiting_q[i], ST_LISTED, n,
						i == n - 1));
				else
					expected_rsp_q.push_back(make_rsp(waiting_q[i], ST_SERVED,
						n - 1 - i, i == n - 1));
			end
			if (beat.op == OP_DRAIN)
				waiting_q.delete();
			return n;
		end
		OP_CLOSE: begin
			expected_rsp_q.push_back(make_rsp('0, (n != 0) ? ST_DISCARDED : ST_CLOSED,
				0, 1'b1));
			waiting_q.delete();
			return 1;
		end
		default: begin
			return 0;
		end
		endcase
	endfunction

	// Random idle decision shared by both channels, off inside the steady window.
	function automatic bit gap_now();
		if (cycle_count >= SteadyFrom && cycle_count < SteadyTo)
			return 1'b0;
		return $urandom_range(99) < 20;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Request driver: predicts on each accepted beat, then loads the next one.
	always @(posedge clk or negedge arst_n) begin : drive_req
		pending_t item;
		bit load;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready)
				predicted_count <= predicted_count + predict_results(req);
			if (!req_valid || req_ready) begin
				load = 1'b0;
				if (pending_q.size() != 0 && !gap_now()) begin
					// A marked beat waits until every predicted response has arrived.
					if (!pending_q[0].settle_first ||
							(!req_valid && predicted_count == received_count))
						load = 1'b1;
				end
				if (load) begin
					item = pending_q.pop_front();
					req_valid <= 1'b1;
					req       <= item.beat;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compares each accepted beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				received_count <= received_count + 1;
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected response beat: record %0d status %0d",
						rsp.record_number_res, rsp.status);
					error_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("record_number_res", 32'(want.record_number_res),
						32'(rsp.record_number_res));
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("waiting_count", 32'(want.waiting_count),
						32'(rsp.waiting_count));
					check_field("last", 32'(want.last), 32'(rsp.last));
				end
			end
			rsp_ready <= !gap_now();
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == StallLimit) begin
			$display("tb_dedup_fifo_queue failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void add_item(logic [OpW-1:0] op, logic [RecW-1:0] rec,
			bit settle = 1'b0);
		pending_t item;
		item.beat.op            = op;
		item.beat.record_number = rec;
		item.settle_first       = settle;
		pending_q.push_back(item);
		if (op <= OP_CLOSE)
			real_items++;
	endfunction

	initial begin : stimulus
		logic [RecW-1:0] pool[PoolSize];
		int unsigned kind;
		int unsigned pick;
		bit settle;

		// Directed: operations on an empty queue and ignored codes.
		add_item(OP_DEQUEUE, 16'h0000);
		add_item(OP_LIST, 16'hFFFF);
		add_item(OP_DRAIN, 16'h0000);
		add_item(OP_CLOSE, 16'hFFFF);
		add_item(OP_RESERVED_LO, 16'h1234);
		add_item(OP_RESERVED_HI, 16'hFFFF);
		// Extreme record numbers, a duplicate, list, serve and a short drain.
		add_item(OP_ENQUEUE, 16'h0000);
		add_item(OP_ENQUEUE, 16'hFFFF);
		add_item(OP_ENQUEUE, 16'hA5A5);
		add_item(OP_ENQUEUE, 16'hFFFF);
		add_item(OP_LIST, 16'h0000);
		add_item(OP_DEQUEUE, 16'h0000);
		add_item(OP_DRAIN, 16'h0000);
		add_item(OP_CLOSE, 16'h0000);
		add_item(OP_ENQUEUE, 16'h5A5A);
		add_item(OP_CLOSE, 16'h0000);

		// Fill to the limit, overflow, then a duplicate while full. The burst
		// starts only once every earlier response has come back.
		for (int i = 0; i < Depth; i++)
			add_item(OP_ENQUEUE, RecW'(16'h0100 + i), i == 0);
		add_item(OP_ENQUEUE, 16'hBEEF);
		add_item(OP_ENQUEUE, 16'h0105);
		add_item(OP_LIST, 16'h0000);
		add_item(OP_DRAIN, 16'h0000);

		// A small pool of record numbers keeps duplicates frequent.
		foreach (pool[i])
			pool[i] = RecW'($urandom_range(16'hFFFF));
		pool[0] = '0;
		pool[1] = '1;

		while (real_items < ItemTarget) begin
			kind   = $urandom_range(9);
			settle = ($urandom_range(39) == 0);
			if (kind < 5) begin
				// Enqueue burst, sometimes past full, closed by one other operation.
				repeat ($urandom_range(Depth + 3, 1)) begin
					if ($urandom_range(4) == 0)
						add_item(OP_ENQUEUE, RecW'($urandom), settle);
					else
						add_item(OP_ENQUEUE, pool[$urandom_range(PoolSize - 1)], settle);
					settle = 1'b0;
				end
				add_item(OP_ENQUEUE + OpW'($urandom_range(OP_CLOSE, OP_DEQUEUE)),
					RecW'($urandom));
			end else begin
				// Mixed operations with random record numbers.
				repeat ($urandom_range(12, 4)) begin
					pick = $urandom_range(99);
					if (pick < 45)
						add_item(OP_ENQUEUE, pool[$urandom_range(PoolSize - 1)], settle);
					else if (pick < 70)
						add_item(OP_DEQUEUE, RecW'($urandom), settle);
					else if (pick < 82)
						add_item(OP_LIST, RecW'($urandom), settle);
					else if (pick < 88)
						add_item(OP_DRAIN, RecW'($urandom), settle);
					else if (pick < 94)
						add_item(OP_CLOSE, RecW'($urandom), settle);
					else
						add_item(OpW'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)),
							RecW'($urandom), settle);
					settle = 1'b0;
				end
			end
		end

		// Hold reset, then release it between edges.
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Wait until every beat is sent and every response is back.
		while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);

		if (error_count == 0)
			$display("tb_dedup_fifo_queue passed");
		else
			$display("tb_dedup_fifo_queue failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/dfq_pkg.sv
hdl/dedup_fifo_queue.sv
tb/tb_dedup_fifo_queue.sv
